>>> hw/rtl/vlhc_pkg.sv
// ----------------------------------------------------------------------------
// vlhc_pkg: shared types for the vehicle lamp and horn controller
// Payload structs, the configuration register set, register index codes
// and reset values used by the controller modules.
// ----------------------------------------------------------------------------
package vlhc_pkg;

    // Width of every configuration register and command byte.
    localparam int ByteW    = 8;
    localparam int CfgIdxW  = 2;

    // Reset values of the configuration registers.
    localparam logic [ByteW-1:0] BlinkTicksRst   = 8'd50;
    localparam logic [ByteW-1:0] HornFirstOffRst = 8'd20;
    localparam logic [ByteW-1:0] HornSecondOnRst = 8'd40;
    localparam logic [ByteW-1:0] HornEndRst      = 8'd70;

    // Bit positions inside the command bytes.
    localparam int C1HighBeam  = 0;
    localparam int C1LowBeam   = 1;
    localparam int C1Driving   = 2;
    localparam int C1Brake     = 3;
    localparam int C1Rear      = 4;
    localparam int C1Warn      = 5;
    localparam int C1Left      = 6;
    localparam int C1Right     = 7;
    localparam int C2Hazard    = 0;
    localparam int C2HornPat   = 1;
    localparam int C2HornCont  = 2;
    localparam int C2Relay     = 3;

    // Configuration register index codes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_BLINK_TICKS    = 2'd0,
        CFG_HORN_FIRST_OFF = 2'd1,
        CFG_HORN_SECOND_ON = 2'd2,
        CFG_HORN_END       = 2'd3
    } vlhc_cfg_idx_t;

    // Configuration register set.
    typedef struct packed {
        logic [ByteW-1:0] blink_ticks;
        logic [ByteW-1:0] horn_first_off;
        logic [ByteW-1:0] horn_second_on;
        logic [ByteW-1:0] horn_end;
    } vlhc_cfg_t;

    // One input item (one tick).
    typedef struct packed {
        logic             load_commands;
        logic [ByteW-1:0] command_one;
        logic [ByteW-1:0] command_two;
        logic             brake_slave_on;
    } vlhc_in_t;

    // One result item: active-low pin levels.
    typedef struct packed {
        logic high_beam_n;
        logic low_beam_n;
        logic driving_lamp_n;
        logic brake_lamp_n;
        logic rear_lamp_n;
        logic warn_lamp_n;
        logic left_lamp_n;
        logic right_lamp_n;
        logic horn_n;
        logic relay_n;
    } vlhc_out_t;

    // Blink mode requests handed to the blink unit.
    typedef struct packed {
        logic hazard;
        logic left;
        logic right;
    } vlhc_blink_req_t;

endpackage

>>> hw/rtl/vlhc_blink.sv
// ----------------------------------------------------------------------------
// vlhc_blink: turn and hazard lamp blink unit
// Holds the three blink counters and the two lamp levels, and gives the
// levels that result from the tick being committed.
// ----------------------------------------------------------------------------
module vlhc_blink (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  vlhc_pkg::vlhc_blink_req_t     req,
    input  logic [vlhc_pkg::ByteW-1:0]    blink_ticks,
    output logic                          left_level,
    output logic                          right_level
);

    logic [vlhc_pkg::ByteW-1:0] hazard_cnt_reg, hazard_cnt_next;
    logic [vlhc_pkg::ByteW-1:0] left_cnt_reg, left_cnt_next;
    logic [vlhc_pkg::ByteW-1:0] right_cnt_reg, right_cnt_next;
    logic                       left_lvl_reg, left_lvl_next;
    logic                       right_lvl_reg, right_lvl_next;
    logic [vlhc_pkg::ByteW-1:0] hazard_inc, left_inc, right_inc;

    // Counters advance with 8-bit wrap.
    assign hazard_inc = hazard_cnt_reg + 8'd1;
    assign left_inc   = left_cnt_reg + 8'd1;
    assign right_inc  = right_cnt_reg + 8'd1;

    // Hazard beats left turn, and left turn beats right turn.
    always_comb
    begin
        hazard_cnt_next = '0;
        left_cnt_next   = '0;
        right_cnt_next  = '0;
        left_lvl_next   = left_lvl_reg;
        right_lvl_next  = right_lvl_reg;
        if (req.hazard)
        begin
            if (hazard_inc >= blink_ticks)
            begin
                left_lvl_next  = ~left_lvl_reg;
                right_lvl_next = ~left_lvl_reg;
            end
            else
            begin
                hazard_cnt_next = hazard_inc;
            end
        end
        else if (req.left)
        begin
            if (left_inc >= blink_ticks)
            begin
                left_lvl_next = ~left_lvl_reg;
            end
            else
            begin
                left_cnt_next = left_inc;
            end
        end
        else if (req.right)
        begin
            if (right_inc >= blink_ticks)
            begin
                right_lvl_next = ~right_lvl_reg;
            end
            else
            begin
                right_cnt_next = right_inc;
            end
        end
        else
        begin
            left_lvl_next  = 1'b1;
            right_lvl_next = 1'b1;
        end
    end

    // State moves only when a tick is committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hazard_cnt_reg <= '0;
            left_cnt_reg   <= '0;
            right_cnt_reg  <= '0;
            left_lvl_reg   <= 1'b1;
            right_lvl_reg  <= 1'b1;
        end
        else if (update)
        begin
            hazard_cnt_reg <= hazard_cnt_next;
            left_cnt_reg   <= left_cnt_next;
            right_cnt_reg  <= right_cnt_next;
            left_lvl_reg   <= left_lvl_next;
            right_lvl_reg  <= right_lvl_next;
        end
    end

    assign left_level  = left_lvl_next;
    assign right_level = right_lvl_next;

endmodule

>>> hw/rtl/vlhc_horn.sv
// ----------------------------------------------------------------------------
// vlhc_horn: horn pattern unit
// Runs the one-shot on, off, on horn pattern, lets the continuous command
// override it, and asks for the pattern bit to be cleared when it ends.
// ----------------------------------------------------------------------------
module vlhc_horn (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  logic                  pattern_on,
    input  logic                  continuous_on,
    input  vlhc_pkg::vlhc_cfg_t   cfg,
    output logic                  horn_n,
    output logic                  pattern_done
);

    logic [vlhc_pkg::ByteW-1:0] count_reg, count_next;
    logic [vlhc_pkg::ByteW-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    // The tests are applied in a fixed order; overlapping settings follow it.
    always_comb
    begin
        count_next   = count_reg;
        horn_n       = 1'b1;
        pattern_done = 1'b0;
        if (continuous_on)
        begin
            horn_n = 1'b0;
        end
        else if (!pattern_on)
        begin
            count_next = '0;
        end
        else if ((count_inc >= cfg.horn_first_off) && (count_inc < cfg.horn_second_on))
        begin
            count_next = count_inc;
        end
        else if ((count_inc >= cfg.horn_second_on) && (count_inc <= cfg.horn_end))
        begin
            count_next = count_inc;
            horn_n     = 1'b0;
        end
        else if (count_inc >= cfg.horn_end)
        begin
            count_next   = '0;
            pattern_done = 1'b1;
        end
        else
        begin
            count_next = count_inc;
            horn_n     = 1'b0;
        end
    end

    // Pattern counter, updated only on a committed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (update)
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/vehicle_lamp_horn_controller_core.sv
// ----------------------------------------------------------------------------
// vehicle_lamp_horn_controller_core: lamp, relay and horn pin controller
// Takes one tick per transfer, optionally loads new command bytes, and
// returns the active-low pin levels for that tick.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_stall    vlhc_in_t  (one tick)
//   out       output     out_valid / out_stall  vlhc_out_t (pin levels)
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One tick per clock is sustained while the output is not stalled; a tick
// passes the input register and then the result register before its result
// can transfer.
// Reset is asynchronous and active low; it restores the register defaults,
// clears the commands and turns both turn lamps off.
// A stall on the output holds the result register, and the input stage then
// stalls only once it also holds a tick. cfg_ready is always high.
// ----------------------------------------------------------------------------
module vehicle_lamp_horn_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  vlhc_pkg::vlhc_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output vlhc_pkg::vlhc_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vlhc_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [vlhc_pkg::ByteW-1:0]          cfg_data
);

    vlhc_pkg::vlhc_cfg_t        cfg_reg;
    logic                       s1_vld_reg;
    vlhc_pkg::vlhc_in_t         s1_data_reg;
    logic                       o_vld_reg;
    vlhc_pkg::vlhc_out_t        o_data_reg, o_data_next;
    logic [vlhc_pkg::ByteW-1:0] cmd_one_reg, cmd_one_next;
    logic [vlhc_pkg::ByteW-1:0] cmd_two_reg, cmd_two_next;
    logic [vlhc_pkg::ByteW-1:0] c1, c2;
    logic                       out_adv;
    logic                       commit;
    logic                       in_take;
    logic                       left_level, right_level;
    logic                       horn_n;
    logic                       pattern_done;
    vlhc_pkg::vlhc_blink_req_t  blink_req;

    // Handshake control: the result register empties or is taken this cycle.
    assign out_adv   = !o_vld_reg || !out_stall;
    assign commit    = s1_vld_reg && out_adv;
    assign in_stall  = s1_vld_reg && !out_adv;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = o_vld_reg;
    assign out_data  = o_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_ticks    <= vlhc_pkg::BlinkTicksRst;
            cfg_reg.horn_first_off <= vlhc_pkg::HornFirstOffRst;
            cfg_reg.horn_second_on <= vlhc_pkg::HornSecondOnRst;
            cfg_reg.horn_end       <= vlhc_pkg::HornEndRst;
        end
        else if (cfg_valid)
        begin
            case (vlhc_pkg::vlhc_cfg_idx_t'(cfg_index))
                vlhc_pkg::CFG_BLINK_TICKS:    cfg_reg.blink_ticks    <= cfg_data;
                vlhc_pkg::CFG_HORN_FIRST_OFF: cfg_reg.horn_first_off <= cfg_data;
                vlhc_pkg::CFG_HORN_SECOND_ON: cfg_reg.horn_second_on <= cfg_data;
                vlhc_pkg::CFG_HORN_END:       cfg_reg.horn_end       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Effective command bytes for this tick.
    assign c1 = s1_data_reg.load_commands ? s1_data_reg.command_one : cmd_one_reg;
    assign c2 = s1_data_reg.load_commands ? s1_data_reg.command_two : cmd_two_reg;

    assign blink_req.hazard = c2[vlhc_pkg::C2Hazard];
    assign blink_req.left   = c1[vlhc_pkg::C1Left];
    assign blink_req.right  = c1[vlhc_pkg::C1Right];

    vlhc_blink u_blink (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (commit),
        .req         (blink_req),
        .blink_ticks (cfg_reg.blink_ticks),
        .left_level  (left_level),
        .right_level (right_level)
    );

    vlhc_horn u_horn (
        .clk           (clk),
        .rst_n         (rst_n),
        .update        (commit),
        .pattern_on    (c2[vlhc_pkg::C2HornPat]),
        .continuous_on (c2[vlhc_pkg::C2HornCont]),
        .cfg           (cfg_reg),
        .horn_n        (horn_n),
        .pattern_done  (pattern_done)
    );

    // Stored commands; a finished horn pattern clears its own bit.
    always_comb
    begin
        cmd_one_next = c1;
        cmd_two_next = c2;
        if (pattern_done)
        begin
            cmd_two_next[vlhc_pkg::C2HornPat] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_one_reg <= '0;
            cmd_two_reg <= '0;
        end
        else if (commit)
        begin
            cmd_one_reg <= cmd_one_next;
            cmd_two_reg <= cmd_two_next;
        end
    end

    // Pin decode for the result.
    always_comb
    begin
        o_data_next.high_beam_n    = ~c1[vlhc_pkg::C1HighBeam];
        o_data_next.low_beam_n     = ~c1[vlhc_pkg::C1LowBeam];
        o_data_next.driving_lamp_n = ~c1[vlhc_pkg::C1Driving];
        o_data_next.brake_lamp_n   = ~c1[vlhc_pkg::C1Brake] & s1_data_reg.brake_slave_on;
        o_data_next.rear_lamp_n    = ~c1[vlhc_pkg::C1Rear];
        o_data_next.warn_lamp_n    = ~c1[vlhc_pkg::C1Warn];
        o_data_next.left_lamp_n    = left_level;
        o_data_next.right_lamp_n   = right_level;
        o_data_next.horn_n         = horn_n;
        o_data_next.relay_n        = ~c2[vlhc_pkg::C2Relay];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            o_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            o_data_reg <= o_data_next;
        end
    end

    // The input side only stalls while the input register holds a tick.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> s1_vld_reg)
        else $error("input stalled with an empty input register");

    // With no blink command both turn lamps are reported off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !blink_req.hazard && !blink_req.left && !blink_req.right)
        |=> (out_data.left_lamp_n && out_data.right_lamp_n))
        else $error("turn lamps not off without a blink command");

    // The continuous horn command always sounds the horn.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && c2[vlhc_pkg::C2HornCont]) |=> !out_data.horn_n)
        else $error("continuous horn not sounding");

    // A committed tick always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n) commit |=> out_valid)
        else $error("committed tick produced no result");

endmodule

>>> dv/tb_vehicle_lamp_horn_controller_core.sv
// ----------------------------------------------------------------------------
// tb_vehicle_lamp_horn_controller_core: self-checking bench for the lamp core
// Drives ticks from a queue of pending items, predicts the pin levels of each
// accepted tick with a local model of the blink and horn logic, and checks
// every result transfer against the oldest predicted one. The run steps
// through several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_vehicle_lamp_horn_controller_core;
    import vlhc_pkg::*;

    localparam int TicksPerPhase = 225;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    vlhc_in_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    vlhc_out_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [ByteW-1:0]    cfg_data = '0;

    // Stimulus and expectation stores.
    vlhc_in_t  pending_ticks[$];
    vlhc_out_t pins_expected[$];
    bit        gaps_on = 1'b1;
    int        mismatches = 0;

    // Local copy of the register set and of the controller state.
    logic [7:0] blink_period = BlinkTicksRst;
    logic [7:0] first_off_at = HornFirstOffRst;
    logic [7:0] second_on_at = HornSecondOnRst;
    logic [7:0] pattern_end  = HornEndRst;
    logic [7:0] cmd_one = '0;
    logic [7:0] cmd_two = '0;
    logic       left_lvl = 1'b1;
    logic       right_lvl = 1'b1;
    logic [7:0] left_cnt = '0;
    logic [7:0] right_cnt = '0;
    logic [7:0] hazard_cnt = '0;
    logic [7:0] horn_cnt = '0;

    vehicle_lamp_horn_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Advance the local state by one tick and return the expected pin levels.
    function automatic vlhc_out_t lamp_pins_for_tick(vlhc_in_t t);
        vlhc_out_t p;
        logic      horn_n;
        if (t.load_commands)
        begin
            cmd_one = t.command_one;
            cmd_two = t.command_two;
        end
        // Blink modes in priority order: hazard, left, right, none.
        if (cmd_two[C2Hazard])
        begin
            left_cnt = '0;
            right_cnt = '0;
            hazard_cnt = hazard_cnt + 8'd1;
            if (hazard_cnt >= blink_period)
            begin
                left_lvl = ~left_lvl;
                right_lvl = left_lvl;
                hazard_cnt = '0;
            end
        end
        else if (cmd_one[C1Left])
        begin
            hazard_cnt = '0;
            right_cnt = '0;
            left_cnt = left_cnt + 8'd1;
            if (left_cnt >= blink_period)
            begin
                left_lvl = ~left_lvl;
                left_cnt = '0;
            end
        end
        else if (cmd_one[C1Right])
        begin
            hazard_cnt = '0;
            left_cnt = '0;
            right_cnt = right_cnt + 8'd1;
            if (right_cnt >= blink_period)
            begin
                right_lvl = ~right_lvl;
                right_cnt = '0;
            end
        end
        else
        begin
            left_cnt = '0;
            right_cnt = '0;
            hazard_cnt = '0;
            left_lvl = 1'b1;
            right_lvl = 1'b1;
        end
        // The horn pattern only advances while the continuous horn is off.
        horn_n = ~cmd_two[C2HornCont];
        if (horn_n)
        begin
            if (!cmd_two[C2HornPat])
            begin
                horn_cnt = '0;
            end
            else
            begin
                horn_cnt = horn_cnt + 8'd1;
                if (horn_cnt >= first_off_at && horn_cnt < second_on_at)
                    horn_n = 1'b1;
                else if (horn_cnt >= second_on_at && horn_cnt <= pattern_end)
                    horn_n = 1'b0;
                else if (horn_cnt >= pattern_end)
                begin
                    cmd_two[C2HornPat] = 1'b0;
                    horn_cnt = '0;
                    horn_n = 1'b1;
                end
                else
                    horn_n = 1'b0;
            end
        end
        p.high_beam_n    = ~cmd_one[C1HighBeam];
        p.low_beam_n     = ~cmd_one[C1LowBeam];
        p.driving_lamp_n = ~cmd_one[C1Driving];
        p.brake_lamp_n   = ~cmd_one[C1Brake] & t.brake_slave_on;
        p.rear_lamp_n    = ~cmd_one[C1Rear];
        p.warn_lamp_n    = ~cmd_one[C1Warn];
        p.left_lamp_n    = left_lvl;
        p.right_lamp_n   = right_lvl;
        p.horn_n         = horn_n;
        p.relay_n        = ~cmd_two[C2Relay];
        return p;
    endfunction

    // Tick driver: predicts each accepted transfer, then presents the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pins_expected.push_back(lamp_pins_for_tick(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_ticks.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 25))
                begin
                    in_data <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_pin(string name, logic exp_v, logic act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %b, got %b", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Result monitor with random output stalls.
    always @(posedge clk)
    begin
        vlhc_out_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pins_expected.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    mismatches++;
                end
                else
                begin
                    e = pins_expected.pop_front();
                    check_pin("high_beam_n", e.high_beam_n, out_data.high_beam_n);
                    check_pin("low_beam_n", e.low_beam_n, out_data.low_beam_n);
                    check_pin("driving_lamp_n", e.driving_lamp_n, out_data.driving_lamp_n);
                    check_pin("brake_lamp_n", e.brake_lamp_n, out_data.brake_lamp_n);
                    check_pin("rear_lamp_n", e.rear_lamp_n, out_data.rear_lamp_n);
                    check_pin("warn_lamp_n", e.warn_lamp_n, out_data.warn_lamp_n);
                    check_pin("left_lamp_n", e.left_lamp_n, out_data.left_lamp_n);
                    check_pin("right_lamp_n", e.right_lamp_n, out_data.right_lamp_n);
                    check_pin("horn_n", e.horn_n, out_data.horn_n);
                    check_pin("relay_n", e.relay_n, out_data.relay_n);
                end
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 25);
        end
    end

    task automatic add_tick(bit load, logic [7:0] c1, logic [7:0] c2, bit slave);
        vlhc_in_t t;
        t.load_commands  = load;
        t.command_one    = c1;
        t.command_two    = c2;
        t.brake_slave_on = slave;
        pending_ticks.push_back(t);
    endtask

    // Wait until every tick has been sent and answered, then let the pipe settle.
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || in_valid || pins_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(vlhc_cfg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BLINK_TICKS:    blink_period = val;
            CFG_HORN_FIRST_OFF: first_off_at = val;
            CFG_HORN_SECOND_ON: second_on_at = val;
            CFG_HORN_END:       pattern_end = val;
            default: ;
        endcase
    endtask

    // Mostly a command load followed by a hold run long enough to reach toggles
    // and the end of the horn pattern; the rest are fully random ticks.
    task automatic add_random_ticks(int n);
        int         added;
        int         span;
        int         run;
        logic [7:0] c2;
        added = 0;
        span = int'(blink_period);
        if (pattern_end > span)
            span = int'(pattern_end);
        if (second_on_at > span)
            span = int'(second_on_at);
        span = span + 8;
        while (added < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                c2 = 8'($urandom);
                if ($urandom_range(0, 1))
                begin
                    c2[C2HornCont] = 1'b0;
                    c2[C2HornPat] = 1'b1;
                end
                add_tick(1'b1, 8'($urandom), c2, 1'($urandom));
                added++;
                if ($urandom_range(0, 9) < 3)
                    run = $urandom_range(0, 4);
                else
                    run = $urandom_range(span / 2, span);
                // The phase stops at its tick budget.
                if (run > n - added)
                    run = n - added;
                repeat (run)
                begin
                    add_tick(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
                    added++;
                end
            end
            else
            begin
                add_tick(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                added++;
            end
        end
    endtask

    initial
    begin
        vlhc_cfg_t plan[6];
        plan[0] = '{8'd1, 8'd1, 8'd255, 8'd254};
        plan[1] = '{8'd3, 8'd2, 8'd4, 8'd6};
        plan[2] = '{8'd255, 8'd255, 8'd1, 8'd1};
        plan[3] = '{8'd2, 8'd5, 8'd3, 8'd4};
        plan[4] = '{BlinkTicksRst, HornFirstOffRst, HornSecondOnRst, HornEndRst};
        plan[5] = '{8'($urandom_range(1, 40)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)), 8'($urandom_range(1, 254))};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset register values.
        @(negedge clk);
        add_tick(1'b1, 8'h00, 8'h00, 1'b0);
        add_tick(1'b1, 8'hFF, 8'hFF, 1'b1);
        add_tick(1'b0, 8'hFF, 8'hFF, 1'b0);
        add_tick(1'b1, 8'hC0, 8'hF0, 1'b1);
        for (int k = 0; k < 8; k++)
            add_tick(1'b1, 8'h01 << k, 8'h01 << k, k[0]);
        add_tick(1'b1, 8'h08, 8'h00, 1'b0);
        add_tick(1'b1, 8'h08, 8'h00, 1'b1);
        add_tick(1'b1, 8'hC0, 8'h02, 1'b1);
        add_tick(1'b0, 8'h00, 8'h00, 1'b1);
        add_tick(1'b1, 8'h80, 8'h06, 1'b0);
        add_tick(1'b1, 8'h40, 8'h0B, 1'b1);

        // Random phases, one per register setting; one phase runs without gaps.
        for (int p = 0; p < 6; p++)
        begin
            wait_quiet();
            write_reg(CFG_BLINK_TICKS, plan[p].blink_ticks);
            write_reg(CFG_HORN_FIRST_OFF, plan[p].horn_first_off);
            write_reg(CFG_HORN_SECOND_ON, plan[p].horn_second_on);
            write_reg(CFG_HORN_END, plan[p].horn_end);
            @(negedge clk);
            gaps_on = (p != 1);
            add_random_ticks(TicksPerPhase);
        end
        wait_quiet();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> vehicle_lamp_horn_controller_core.f
hw/rtl/vlhc_pkg.sv
hw/rtl/vlhc_blink.sv
hw/rtl/vlhc_horn.sv
hw/rtl/vehicle_lamp_horn_controller_core.sv
dv/tb_vehicle_lamp_horn_controller_core.sv
